@@ hdl/imm_pkg.sv @@
// ----------------------------------------------------------------------------
// imm_pkg: shared types and constants of the int8 matrix multiply tile
// Lane count, operand and accumulator widths, and the step control bundle
// passed from the input stage to the MAC cells.
// ----------------------------------------------------------------------------
package imm_pkg;

    // Operand lanes per side and derived index width
    localparam int LANES = 4;
    localparam int IDX_W = 2;
    localparam int CELLS = LANES * LANES;

    // Operand and sum widths
    localparam int A_W   = 8;
    localparam int B_W   = 8;
    localparam int ACC_W = 32;
    localparam int PRD_W = A_W + B_W + 1;

    typedef logic        [ACC_W-1:0] t_acc;
    typedef logic        [A_W-1:0]   t_a;
    typedef logic signed [B_W-1:0]   t_b;

    // Step control from the input stage to every cell
    typedef struct packed {
        logic adv;   // step leaves the input register this cycle
        logic last;  // step closes the tile: clear after adding
    } t_step;

endpackage

@@ hdl/imm_mac.sv @@
// ----------------------------------------------------------------------------
// imm_mac: one multiply-accumulate cell of the output-stationary tile
// Adds a(u8) * b(s8) into a wrapping 32-bit accumulator; the updated sum is
// exposed so the drain buffer can capture it on the closing step.
// ----------------------------------------------------------------------------
module imm_mac
    import imm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_step i_step,
    input  t_a    i_a,
    input  t_b    i_b,
    output t_acc  o_sum
);

    t_acc                    r_acc;
    t_acc                    n_acc;
    logic signed [PRD_W-1:0] w_prod;

    // Unsigned A times signed B, sign-extended onto the running sum
    always_comb begin
        w_prod = PRD_W'($signed({1'b0, i_a})) * PRD_W'(i_b);
        o_sum  = r_acc + ACC_W'(w_prod);
        n_acc  = r_acc;
        if (i_step.adv) begin
            n_acc = i_step.last ? '0 : o_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule

@@ hdl/imm_drain.sv @@
// ----------------------------------------------------------------------------
// imm_drain: result buffer and row-major drain of a finished tile
// Captures all sums of a closed tile at once and sends them one transaction
// per cycle while the sink is ready, marking the final one with tlast.
// ----------------------------------------------------------------------------
module imm_drain
    import imm_pkg::*;
#(
    parameter int ACT_ROWS = 4,
    parameter int ACT_COLS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_acc        i_sums [CELLS],
    output logic        o_free,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [1:0] out_row, [3:2] out_col,
                                        // [35:4] sum_value, [39:36] zero
    output logic        m_axis_tlast    // last_result
);

    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(ACT_ROWS - 1);
    localparam logic [IDX_W-1:0] LAST_COL = IDX_W'(ACT_COLS - 1);

    t_acc             r_buf [CELLS];
    logic             r_busy;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic             n_busy;
    logic [IDX_W-1:0] n_row;
    logic [IDX_W-1:0] n_col;
    logic             w_hs;
    logic             w_final;

    assign w_hs    = r_busy && m_axis_tready;
    assign w_final = (r_row == LAST_ROW) && (r_col == LAST_COL);
    assign o_free  = !r_busy || (w_hs && w_final);

    // Advance the row-major position, restart on a new tile
    always_comb begin
        n_busy = r_busy;
        n_row  = r_row;
        n_col  = r_col;
        if (i_load) begin
            n_busy = 1'b1;
            n_row  = '0;
            n_col  = '0;
        end else if (w_hs) begin
            if (w_final) begin
                n_busy = 1'b0;
            end else if (r_col == LAST_COL) begin
                n_col = '0;
                n_row = r_row + IDX_W'(1);
            end else begin
                n_col = r_col + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
            r_col  <= '0;
        end else begin
            r_busy <= n_busy;
            r_row  <= n_row;
            r_col  <= n_col;
        end
    end

    // Capture the whole tile on the closing step
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_sums;
        end
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tlast  = r_busy && w_final;
    assign m_axis_tdata  = {4'b0000, r_buf[{r_row, r_col}], r_col, r_row};

    // A tile is only captured when the buffer is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("tile captured while buffer busy");

    // A capture starts the drain at row 0, column 0
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (m_axis_tvalid && r_row == '0 && r_col == '0))
        else $error("drain did not restart at origin");

    // Final transaction without a new tile empties the buffer
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast && !i_load) |=> !m_axis_tvalid)
        else $error("drain continued past last result");

    // Position never leaves the active tile
    a_in_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_row <= LAST_ROW && r_col <= LAST_COL))
        else $error("drain position outside tile");

endmodule

@@ hdl/int8_matrix_multiply_tile.sv @@
// A tile's sums enter the drain buffer as its closing step leaves the input register.
// One reduction step per cycle; sums leave one per cycle while the sink is ready.
// A closing step waits in the input register while the previous tile still drains
// from the output buffer; other steps keep flowing.
// Reset (synchronous, active low) clears all accumulators and empties both stages.
// ----------------------------------------------------------------------------
// int8_matrix_multiply_tile: output-stationary u8 x s8 GEMM tile, int32 sums
// Registers one reduction step, adds its outer product into the MAC cells and
// hands the finished tile to the drain buffer on the step marked last.
// ----------------------------------------------------------------------------
module int8_matrix_multiply_tile
    import imm_pkg::*;
#(
    parameter int TILE_ROWS = 4,
    parameter int TILE_COLS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // a_col_0..a_col_3, b_row_0..b_row_3,
                                        // 8 bits each from the lowest bit up
    input  logic        s_axis_tlast,   // last_step
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_row(2), out_col(2), sum_value(32), zero(4)
    output logic        m_axis_tlast    // last_result
);

    localparam int ACT_ROWS = (TILE_ROWS < 1) ? 1 : ((TILE_ROWS > LANES) ? LANES : TILE_ROWS);
    localparam int ACT_COLS = (TILE_COLS < 1) ? 1 : ((TILE_COLS > LANES) ? LANES : TILE_COLS);

    logic  r_in_valid;
    logic  r_last;
    t_a    r_a [LANES];
    t_b    r_b [LANES];
    logic  w_free;
    t_step w_step;
    t_acc  w_sums [CELLS];

    // Step leaves the input register unless it closes a tile the buffer cannot take
    assign w_step.adv  = r_in_valid && (!r_last || w_free);
    assign w_step.last = r_last;
    assign s_axis_tready = !r_in_valid || w_step.adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Hold the operand slices for the MAC cells
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_last <= s_axis_tlast;
            for (int i = 0; i < LANES; i++) begin
                r_a[i] <= s_axis_tdata[i*A_W +: A_W];
                r_b[i] <= s_axis_tdata[LANES*A_W + i*B_W +: B_W];
            end
        end
    end

    // One MAC cell per active tile element
    for (genvar gr = 0; gr < LANES; gr++) begin : g_row
        for (genvar gc = 0; gc < LANES; gc++) begin : g_col
            if (gr < ACT_ROWS && gc < ACT_COLS) begin : g_cell
                imm_mac u_mac (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_step  (w_step),
                    .i_a     (r_a[gr]),
                    .i_b     (r_b[gc]),
                    .o_sum   (w_sums[gr*LANES + gc])
                );
            end else begin : g_none
                assign w_sums[gr*LANES + gc] = '0;
            end
        end
    end

    imm_drain #(
        .ACT_ROWS (ACT_ROWS),
        .ACT_COLS (ACT_COLS)
    ) u_drain (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_step.adv && w_step.last),
        .i_sums        (w_sums),
        .o_free        (w_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ tb/int8_matrix_multiply_tile_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_matrix_multiply_tile_tb: self-checking bench for the u8 x s8 GEMM tile
// Streams reduction steps into the tile engine, keeps its own int32 tile
// accumulators to predict every emitted sum, and checks each output
// transaction field by field under varied source gaps and sink stalls.
// ----------------------------------------------------------------------------
module int8_matrix_multiply_tile_tb;
    import imm_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS  = 30;

    typedef logic [LANES-1:0][A_W-1:0] t_a_slice;
    typedef logic [LANES-1:0][B_W-1:0] t_b_slice;

    typedef struct {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        t_acc             sum;
        logic             is_last;
    } t_tile_sum;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;    // a_col_0..a_col_3, b_row_0..b_row_3
    logic        s_axis_tlast = 1'b0;  // last_step
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // out_row, out_col, sum_value, zero pad
    logic        m_axis_tlast;         // last_result

    // Predicted accumulator tile and the sums it has released
    t_acc      tile_acc [LANES][LANES] = '{default: '0};
    t_tile_sum expected_sums [$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    logic rx_hold = 1'b0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int steps_sent = 0;
    int tiles_closed = 0;
    int sums_checked = 0;

    int8_matrix_multiply_tile uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("tb: mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, field, got, want);
    endtask

    // Add one step's outer product; on the closing step release and clear the tile
    task automatic accumulate_step(input t_a_slice a_vec, input t_b_slice b_vec,
                                   input logic last);
        int prod;
        steps_sent++;
        for (int r = 0; r < LANES; r++) begin
            for (int c = 0; c < LANES; c++) begin
                prod = int'(a_vec[r]) * int'($signed(b_vec[c]));
                tile_acc[r][c] = tile_acc[r][c] + t_acc'(prod);
            end
        end
        if (last) begin
            tiles_closed++;
            for (int r = 0; r < LANES; r++) begin
                for (int c = 0; c < LANES; c++) begin
                    expected_sums.push_back('{row: IDX_W'(r), col: IDX_W'(c),
                                              sum: tile_acc[r][c],
                                              is_last: (r == LANES - 1) && (c == LANES - 1)});
                    tile_acc[r][c] = '0;
                end
            end
        end
    endtask

    // Offer one reduction step and hold it until the tile accepts it
    task automatic send_step(input t_a_slice a_vec, input t_b_slice b_vec, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b_vec, a_vec};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        accumulate_step(a_vec, b_vec, last);
    endtask

    // Drop valid and wait until every predicted sum has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_a_slice pick_a();
        t_a_slice v;
        v = $urandom;
        for (int i = 0; i < LANES; i++)
            if ($urandom_range(7) == 0)
                v[i] = $urandom_range(1) ? 8'hFF : 8'h00;
        return v;
    endfunction

    function automatic t_b_slice pick_b();
        t_b_slice v;
        v = $urandom;
        for (int i = 0; i < LANES; i++)
            if ($urandom_range(7) == 0)
                v[i] = $urandom_range(1) ? 8'h7F : 8'h80;
        return v;
    endfunction

    // Sink side: check each output transaction, then pick the next ready
    always @(posedge i_clk) begin : sum_checker
        t_tile_sum want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_sums.size() == 0) begin
                report_mismatch("unexpected sum", longint'($signed(m_axis_tdata[35:4])), 0);
            end else begin
                want = expected_sums.pop_front();
                sums_checked++;
                if (m_axis_tdata[1:0] !== want.row)
                    report_mismatch("out_row", m_axis_tdata[1:0], want.row);
                if (m_axis_tdata[3:2] !== want.col)
                    report_mismatch("out_col", m_axis_tdata[3:2], want.col);
                if (m_axis_tdata[35:4] !== want.sum)
                    report_mismatch("sum_value", longint'($signed(m_axis_tdata[35:4])),
                                    longint'($signed(want.sum)));
                if (m_axis_tlast !== want.is_last)
                    report_mismatch("last_result", m_axis_tlast, want.is_last);
            end
        end
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Single-step tiles at the operand extremes and alternating bit patterns
    task automatic test_single_step_tiles();
        send_step({4{8'hFF}}, {4{8'h80}}, 1'b1);
        send_step({4{8'hFF}}, {4{8'h7F}}, 1'b1);
        send_step({4{8'h00}}, {8'h80, 8'h7F, 8'hFF, 8'h01}, 1'b1);
        send_step({8'hAA, 8'h55, 8'hAA, 8'h55}, {8'h55, 8'hAA, 8'h55, 8'hAA}, 1'b1);
        send_step({8'h01, 8'h80, 8'h7F, 8'hFE}, {4{8'h00}}, 1'b1);
        wait_drained();
    endtask

    // Accumulate across steps that emit nothing until the closing one
    task automatic test_multi_step_tile();
        for (int k = 0; k < 8; k++)
            send_step({8'hFF, 8'h00, 8'hFF, 8'h80}, {8'h80, 8'h7F, 8'h01, 8'hFF}, k == 7);
        for (int k = 0; k < 4; k++)
            send_step(pick_a(), pick_b(), k == 3);
        wait_drained();
    endtask

    // Close tiles back to back so each closing step after the first waits on the drain
    task automatic test_back_to_back_tiles();
        for (int k = 0; k < 6; k++)
            send_step(pick_a(), pick_b(), 1'b1);
        wait_drained();
    endtask

    // Random tiles, mostly short, some long; the final step always closes a tile
    task automatic test_random_tiles(input int n_steps, input int idle_pct, input int stall_pct);
        int left;
        int len;
        tx_idle_pct = idle_pct;
        rx_stall_pct <= stall_pct;
        left = n_steps;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            if (len > left)
                len = left;
            for (int k = 0; k < len; k++)
                send_step(pick_a(), pick_b(), k == len - 1);
            left -= len;
        end
        wait_drained();
    endtask

    // Hold the sink off for a long stretch while the source keeps offering steps
    task automatic test_output_backpressure();
        int left;
        int len;
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        left = 40;
        while (left > 0) begin
            len = $urandom_range(1, 3);
            if (len > left)
                len = left;
            for (int k = 0; k < len; k++)
                send_step(pick_a(), pick_b(), k == len - 1);
            left -= len;
        end
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_step_tiles();
        test_multi_step_tile();
        test_back_to_back_tiles();
        test_random_tiles(87, 0, 0);
        test_random_tiles(87, 49, 0);
        test_random_tiles(87, 0, 49);
        test_random_tiles(87, 23, 23);
        test_output_backpressure();

        repeat (40) @(posedge i_clk);
        $display("tb: %0d reduction steps in %0d tiles, %0d sums checked, %0d mismatches",
                 steps_sent, tiles_closed, sums_checked, mismatch_count);
        $display("tb: covered operand extremes, idle and stall mixes, sink hold-off");
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/imm_pkg.sv
hdl/imm_mac.sv
hdl/imm_drain.sv
hdl/int8_matrix_multiply_tile.sv
tb/int8_matrix_multiply_tile_tb.sv
